FILE: sv/tlg_pkg.sv
`default_nettype none

package tlg_pkg;

    // Widths of the item fields.
    localparam int CMD_W = 2;
    localparam int IDX_W = 7;

    // Command codes carried by an input item and echoed in its result.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_STEP,
        ST_DONE
    } t_state;

    // Life rule thresholds on the 4-bit neighbor count.
    localparam logic [3:0] LIFE_SURVIVE_LO = 4'd2;
    localparam logic [3:0] LIFE_SURVIVE_HI = 4'd3;
    localparam logic [3:0] LIFE_BIRTH      = 4'd3;

endpackage

`default_nettype wire

FILE: sv/tlg_in_if.sv
`default_nettype none

interface tlg_in_if import tlg_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             cell_in;

    modport source (output valid, output cmd, output row, output col, output cell_in,
                    input ready);
    modport sink   (input valid, input cmd, input row, input col, input cell_in,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/tlg_out_if.sv
`default_nettype none

interface tlg_out_if import tlg_pkg::*;;
    logic             valid;
    logic             ready;
    logic             cell_out;
    logic [CMD_W-1:0] done_cmd;

    modport source (output valid, output cell_out, output done_cmd, input ready);
    modport sink   (input valid, input cell_out, input done_cmd, output ready);
endinterface

`default_nettype wire

FILE: sv/toroidal_life_generation_step_core.sv
`default_nettype none

// Toroidal Game of Life engine (B3/S23) on a GRID_ROWS x GRID_COLS grid.
// Input channel i_in carries one command per item: write one cell, read one
// cell, or advance the whole grid by one generation. Row and column indexes
// wrap modulo the grid size. Output channel o_out returns exactly one result
// item per command: the cell value for a read (0 otherwise) and an echo of
// the command code. The grid lives in one memory of GRID_ROWS rows, each a
// full row of cells, with a registered read.
// A write or read first fetches the addressed row, then writes it back
// modified or picks the cell; an unused command goes straight to its result;
// a generation step walks the single memory, reading one row and writing one
// row per cycle through a three-row window. One item is processed at a
// time; no new item is accepted until the last result has been loaded.
// After reset the memory is cleared one row per cycle, and the block accepts
// no item until every row has been cleared.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and processes the next item and holds its result
// until the output register frees up.

module toroidal_life_generation_step_core import tlg_pkg::*; #(
    parameter int GRID_COLS = 128,
    parameter int GRID_ROWS = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tlg_in_if.sink     i_in,
    tlg_out_if.source  o_out
);

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int KW    = $clog2(GRID_ROWS + 3);
    localparam int IDX_N = 1 << IDX_W;

    localparam logic [RW-1:0] LAST_ROW    = RW'(GRID_ROWS - 1);
    localparam logic [KW-1:0] K_CLEAR_END = KW'(GRID_ROWS - 1);
    localparam logic [KW-1:0] K_TAIL1     = KW'(GRID_ROWS + 1);
    localparam logic [KW-1:0] K_TAIL2     = KW'(GRID_ROWS + 2);
    localparam logic [KW-1:0] K_WR_START  = KW'(3);

    // Index wrap tables: input index modulo the grid size.
    logic [RW-1:0] row_tbl [IDX_N];
    logic [CW-1:0] col_tbl [IDX_N];

    for (genvar k = 0; k < IDX_N; k++) begin : g_wrap
        assign row_tbl[k] = RW'(k % GRID_ROWS);
        assign col_tbl[k] = CW'(k % GRID_COLS);
    end

    // Control and payload registers.
    t_state          r_state, n_state;
    logic [KW-1:0]   r_k, n_k;
    t_cmd            r_cmd, n_cmd;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic            r_cin, n_cin;
    logic            r_res, n_res;
    logic            r_ovalid, n_ovalid;
    logic            r_ocell, n_ocell;
    t_cmd            r_ocmd, n_ocmd;
    logic [GRID_COLS-1:0] r_up, n_up;
    logic [GRID_COLS-1:0] r_mid, n_mid;
    logic [GRID_COLS-1:0] r_first, n_first;
    logic [GRID_COLS-1:0] r_last, n_last;

    // Memory port signals.
    logic                 mem_we;
    logic [RW-1:0]        mem_waddr;
    logic [RW-1:0]        mem_raddr;
    logic [GRID_COLS-1:0] mem_wdata;
    logic [GRID_COLS-1:0] r_rdata;
    logic [GRID_COLS-1:0] mem [GRID_ROWS];

    logic [GRID_COLS-1:0] w_dn;
    logic [GRID_COLS-1:0] w_next;
    logic [KW-1:0]        w_km1;
    logic [KW-1:0]        w_km3;
    logic                 w_ofree;
    logic                 w_in_ready;

    // Grid memory: one row written and one row read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Row below the current one: the fresh read, then the saved wrap rows.
    assign w_dn = (r_k == K_TAIL1) ? r_last :
                  (r_k == K_TAIL2) ? r_first : r_rdata;

    // Next generation of one row from the three-row window.
    for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
        localparam int LF = (c == 0) ? GRID_COLS - 1 : c - 1;
        localparam int RT = (c == GRID_COLS - 1) ? 0 : c + 1;
        logic [3:0] cnt;

        assign cnt = 4'(r_up[LF]) + 4'(r_up[c]) + 4'(r_up[RT])
                   + 4'(r_mid[LF]) + 4'(r_mid[RT])
                   + 4'(w_dn[LF]) + 4'(w_dn[c]) + 4'(w_dn[RT]);
        assign w_next[c] = r_mid[c] ? (cnt >= LIFE_SURVIVE_LO && cnt <= LIFE_SURVIVE_HI)
                                    : (cnt == LIFE_BIRTH);
    end

    assign w_km1   = r_k - KW'(1);
    assign w_km3   = r_k - K_WR_START;
    assign w_ofree = !r_ovalid || o_out.ready;

    // Sequencer: next state, memory control and result loading.
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_cmd      = r_cmd;
        n_row      = r_row;
        n_col      = r_col;
        n_cin      = r_cin;
        n_res      = r_res;
        n_up       = r_up;
        n_mid      = r_mid;
        n_first    = r_first;
        n_last     = r_last;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_ocell    = r_ocell;
        n_ocmd     = r_ocmd;
        mem_we     = 1'b0;
        mem_waddr  = w_km3[RW-1:0];
        mem_wdata  = w_next;
        mem_raddr  = row_tbl[i_in.row];
        w_in_ready = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[RW-1:0];
                mem_wdata = '0;
                if (r_k == K_CLEAR_END) begin
                    n_k     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_cmd = t_cmd'(i_in.cmd);
                    n_row = row_tbl[i_in.row];
                    n_col = col_tbl[i_in.col];
                    n_cin = i_in.cell_in;
                    n_res = 1'b0;
                    n_k   = '0;
                    case (t_cmd'(i_in.cmd))
                        CMD_WRITE: n_state = ST_CELL;
                        CMD_READ:  n_state = ST_CELL;
                        CMD_STEP:  n_state = ST_STEP;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_CELL: begin
                // The addressed row has arrived; modify it or pick the cell.
                if (r_cmd == CMD_WRITE) begin
                    mem_we           = 1'b1;
                    mem_waddr        = r_row;
                    mem_wdata        = r_rdata;
                    mem_wdata[r_col] = r_cin;
                end else begin
                    n_res = r_rdata[r_col];
                end
                n_state = ST_DONE;
            end
            ST_STEP: begin
                // Reads go last row first, then rows 0 upward; each new row is
                // written as soon as the row below it is in the window.
                mem_raddr = (r_k == '0) ? LAST_ROW : w_km1[RW-1:0];
                if (r_k != '0) begin
                    n_up  = r_mid;
                    n_mid = w_dn;
                end
                if (r_k == KW'(1)) begin
                    n_last = r_rdata;
                end
                if (r_k == KW'(2)) begin
                    n_first = r_rdata;
                end
                if (r_k >= K_WR_START) begin
                    mem_we = 1'b1;
                end
                if (r_k == K_TAIL2) begin
                    n_state = ST_DONE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            ST_DONE: begin
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_ocell  = r_res;
                    n_ocmd   = r_cmd;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_row   <= n_row;
        r_col   <= n_col;
        r_cin   <= n_cin;
        r_res   <= n_res;
        r_up    <= n_up;
        r_mid   <= n_mid;
        r_first <= n_first;
        r_last  <= n_last;
        r_ocell <= n_ocell;
        r_ocmd  <= n_ocmd;
    end

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_ovalid;
    assign o_out.cell_out = r_ocell;
    assign o_out.done_cmd = r_ocmd;

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
    import tlg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_ROWS   = 128;
    localparam int GRID_COLS   = 128;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    // One result item as the block returns it.
    typedef struct packed {
        logic cell_out;
        t_cmd done_cmd;
    } t_cell_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlg_in_if  in_ch ();
    tlg_out_if out_ch ();

    toroidal_life_generation_step_core #(
        .GRID_COLS(GRID_COLS),
        .GRID_ROWS(GRID_ROWS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Shadow copy of the grid; bit c of row r is the cell at (r, c).
    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
    t_cell_result         pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int stall_left    = 0;
    int mismatch_count = 0;
    int idle_cycles   = 0;

    always #5 i_clk = ~i_clk;

    // Advance the shadow grid by one generation. The eight neighbor rows are
    // summed bit-parallel into a 4-bit count per column.
    function automatic void advance_life();
        logic [GRID_COLS-1:0] next_grid [GRID_ROWS];
        logic [GRID_COLS-1:0] nb [8];
        logic [GRID_COLS-1:0] up, mid, dn, b0, b1, b2, b3, k, k2;
        int r;
        for (r = 0; r < GRID_ROWS; r++) begin
            up  = life_grid[(r + GRID_ROWS - 1) % GRID_ROWS];
            mid = life_grid[r];
            dn  = life_grid[(r + 1) % GRID_ROWS];
            nb[0] = {up[GRID_COLS-2:0], up[GRID_COLS-1]};
            nb[1] = up;
            nb[2] = {up[0], up[GRID_COLS-1:1]};
            nb[3] = {mid[GRID_COLS-2:0], mid[GRID_COLS-1]};
            nb[4] = {mid[0], mid[GRID_COLS-1:1]};
            nb[5] = {dn[GRID_COLS-2:0], dn[GRID_COLS-1]};
            nb[6] = dn;
            nb[7] = {dn[0], dn[GRID_COLS-1:1]};
            b0 = '0;
            b1 = '0;
            b2 = '0;
            b3 = '0;
            foreach (nb[i]) begin
                k  = nb[i];
                k2 = b0 & k;
                b0 = b0 ^ k;
                k  = k2;
                k2 = b1 & k;
                b1 = b1 ^ k;
                k  = k2;
                k2 = b2 & k;
                b2 = b2 ^ k;
                b3 = b3 | k2;
            end
            // Count of three gives a live cell; count of two keeps a live one.
            next_grid[r] = ~b3 & ~b2 & b1 & (b0 | mid);
        end
        life_grid = next_grid;
    endfunction

    // Apply one command to the shadow grid and return the result it yields.
    function automatic t_cell_result apply_life_cmd(input t_cmd cmd,
                                                    input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col,
                                                    input logic val);
        t_cell_result res;
        int r;
        int c;
        r = int'(row) % GRID_ROWS;
        c = int'(col) % GRID_COLS;
        res.cell_out = 1'b0;
        res.done_cmd = cmd;
        case (cmd)
            CMD_WRITE: life_grid[r][c] = val;
            CMD_READ:  res.cell_out = life_grid[r][c];
            CMD_STEP:  advance_life();
            default: ;
        endcase
        return res;
    endfunction

    // Row or column base for a pattern; one in four lands across the wrap.
    function automatic logic [IDX_W-1:0] pick_base();
        if ($urandom_range(0, 3) == 0) begin
            return IDX_W'($urandom_range(GRID_ROWS - 4, GRID_ROWS + 1));
        end
        return IDX_W'($urandom);
    endfunction

    // Offer one item, idling at random first, and record its expected result
    // once it is accepted.
    task automatic send_cell_cmd(input t_cmd cmd, input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col, input logic val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid   <= 1'b0;
            in_ch.cmd     <= CMD_W'($urandom);
            in_ch.row     <= IDX_W'($urandom);
            in_ch.col     <= IDX_W'($urandom);
            in_ch.cell_in <= 1'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.row     <= row;
        in_ch.col     <= col;
        in_ch.cell_in <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(apply_life_cmd(cmd, row, col, val));
    endtask

    // Stop offering items and wait until every expected result has come.
    task automatic wait_for_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes and reads at the four corners, the unused command, and a clear.
    task automatic test_corner_cells();
        send_cell_cmd(CMD_WRITE, 7'd0,   7'd0,   1'b1);
        send_cell_cmd(CMD_WRITE, 7'd0,   7'd127, 1'b1);
        send_cell_cmd(CMD_WRITE, 7'd127, 7'd0,   1'b1);
        send_cell_cmd(CMD_WRITE, 7'd127, 7'd127, 1'b1);
        send_cell_cmd(CMD_READ,  7'd0,   7'd0,   1'b0);
        send_cell_cmd(CMD_READ,  7'd0,   7'd127, 1'b1);
        send_cell_cmd(CMD_READ,  7'd127, 7'd0,   1'b0);
        send_cell_cmd(CMD_READ,  7'd127, 7'd127, 1'b1);
        send_cell_cmd(CMD_NONE,  7'd127, 7'd127, 1'b0);
        send_cell_cmd(CMD_READ,  7'd127, 7'd127, 1'b0);
        send_cell_cmd(CMD_WRITE, 7'd127, 7'd127, 1'b0);
        send_cell_cmd(CMD_READ,  7'd127, 7'd127, 1'b1);
    endtask

    // Three corner cells form an L across both wraps: one step births the
    // fourth corner, and the resulting block is still life.
    task automatic test_wrap_step();
        send_cell_cmd(CMD_STEP, 7'd127, 7'd127, 1'b1);
        send_cell_cmd(CMD_READ, 7'd0,   7'd0,   1'b0);
        send_cell_cmd(CMD_READ, 7'd0,   7'd127, 1'b0);
        send_cell_cmd(CMD_READ, 7'd127, 7'd0,   1'b0);
        send_cell_cmd(CMD_READ, 7'd127, 7'd127, 1'b0);
        send_cell_cmd(CMD_READ, 7'd1,   7'd1,   1'b0);
        send_cell_cmd(CMD_READ, 7'd126, 7'd126, 1'b0);
        send_cell_cmd(CMD_STEP, 7'd0,   7'd0,   1'b0);
        send_cell_cmd(CMD_READ, 7'd127, 7'd127, 1'b0);
    endtask

    // Mostly small patterns written into a window, stepped, then read back
    // around the window; the rest is arbitrary commands.
    task automatic test_random_traffic(input int n_items);
        logic [IDX_W-1:0] r0, c0;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                r0 = pick_base();
                c0 = pick_base();
                repeat ($urandom_range(4, 18)) begin
                    send_cell_cmd(CMD_WRITE, r0 + IDX_W'($urandom_range(0, 5)),
                                  c0 + IDX_W'($urandom_range(0, 5)),
                                  $urandom_range(0, 99) < 70);
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    send_cell_cmd(CMD_STEP, IDX_W'($urandom), IDX_W'($urandom),
                                  1'($urandom));
                    sent++;
                end
                repeat ($urandom_range(4, 12)) begin
                    send_cell_cmd(CMD_READ,
                                  r0 + IDX_W'($urandom_range(0, 7)) - 7'd1,
                                  c0 + IDX_W'($urandom_range(0, 7)) - 7'd1,
                                  1'($urandom));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_cell_cmd(t_cmd'($urandom_range(0, 3)), IDX_W'($urandom),
                                  IDX_W'($urandom), 1'($urandom));
                    sent++;
                end
            end
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills up and stalls its input.
    task automatic test_output_backpressure();
        logic [IDX_W-1:0] r0, c0;
        send_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        r0 = pick_base();
        c0 = pick_base();
        repeat (8) begin
            send_cell_cmd(CMD_WRITE, r0 + IDX_W'($urandom_range(0, 3)),
                          c0 + IDX_W'($urandom_range(0, 3)), 1'b1);
        end
        send_cell_cmd(CMD_STEP, r0, c0, 1'b0);
        repeat (8) begin
            send_cell_cmd(CMD_READ, r0 + IDX_W'($urandom_range(0, 5)) - 7'd1,
                          c0 + IDX_W'($urandom_range(0, 5)) - 7'd1, 1'b0);
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each result item with the oldest expectation.
    always @(posedge i_clk) begin
        t_cell_result exp;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, cell_out %0b done_cmd %0d",
                         $time, out_ch.cell_out, out_ch.done_cmd);
                mismatch_count++;
            end else begin
                exp = pending_results.pop_front();
                if (out_ch.cell_out !== exp.cell_out) begin
                    $display("%0t: cell_out mismatch, expected %0b, actual %0b",
                             $time, exp.cell_out, out_ch.cell_out);
                    mismatch_count++;
                end
                if (out_ch.done_cmd !== exp.done_cmd) begin
                    $display("%0t: done_cmd mismatch, expected %0d, actual %0d",
                             $time, exp.done_cmd, out_ch.done_cmd);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_WRITE;
        in_ch.row     = '0;
        in_ch.col     = '0;
        in_ch.cell_in = 1'b0;
        out_ch.ready  = 1'b0;
        foreach (life_grid[r]) life_grid[r] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cells();
        test_wrap_step();
        wait_for_results();

        send_idle_pct = 35;
        recv_idle_pct = 87;
        test_random_traffic(650);
        wait_for_results();

        test_output_backpressure();
        wait_for_results();

        send_idle_pct = 87;
        recv_idle_pct = 35;
        test_random_traffic(650);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(600);
        wait_for_results();

        // Let any stray result show up before the verdict.
        repeat (GRID_ROWS + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
